@@ rtl/core/tftp_write_receiver_macros.svh @@
// Assertion macros for the TFTP write receiver.
`ifndef TFTP_WRITE_RECEIVER_MACROS_SVH
`define TFTP_WRITE_RECEIVER_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define TWR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("twr assertion failed");
// Next-cycle implication, checked out of reset.
`define TWR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("twr assertion failed");
`else
`define TWR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TWR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/twr_pkg.sv @@
// Types, constants and codes shared by the TFTP write receiver modules.
package twr_pkg;

    localparam int PORT_W  = 16;
    localparam int OP_W    = 16;
    localparam int BLKN_W  = 16;
    localparam int PLEN_W  = 11;
    localparam int SOP_W   = 3;
    localparam int WOFF_W  = 22;
    localparam int TICK_W  = 16;
    localparam int IDLE_W  = 17;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam int BLOCK_BYTES_DEF  = 512;
    localparam int BUFFER_BYTES_DEF = 4194304;

    localparam logic [PORT_W-1:0] OUR_PORT_RST = 16'd69;
    localparam logic [TICK_W-1:0] TIMEOUT_RST  = 16'd1000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OUR_PORT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 1'd1;

    // item kinds
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // received opcodes
    localparam logic [OP_W-1:0] OP_RRQ   = 16'd1;
    localparam logic [OP_W-1:0] OP_WRQ   = 16'd2;
    localparam logic [OP_W-1:0] OP_DATA  = 16'd3;
    localparam logic [OP_W-1:0] OP_ERROR = 16'd5;

    // reply opcodes
    localparam logic [SOP_W-1:0] SOP_DATA = 3'd3;
    localparam logic [SOP_W-1:0] SOP_ACK  = 3'd4;

    typedef enum logic [1:0] {
        MODE_LISTEN = 2'd0,
        MODE_WRQ    = 2'd1,
        MODE_DATA   = 2'd2,
        MODE_DONE   = 2'd3
    } t_mode;

    typedef struct packed {
        logic              kind;
        logic [PORT_W-1:0] dest_port;
        logic [PORT_W-1:0] src_port;
        logic [PLEN_W-1:0] packet_len;
        logic [OP_W-1:0]   opcode;
        logic [BLKN_W-1:0] block_number;
    } t_twr_in;

    typedef struct packed {
        logic              send_valid;
        logic [SOP_W-1:0]  send_opcode;
        logic [BLKN_W-1:0] send_number;
        logic [PORT_W-1:0] reply_port;
        logic              write_valid;
        logic [WOFF_W-1:0] write_offset;
        logic [PLEN_W-1:0] write_length;
        logic              overflow;
        logic              done_res;
        logic              restart;
    } t_twr_out;

    typedef struct packed {
        logic [PORT_W-1:0] our_port;
        logic [TICK_W-1:0] timeout_ticks;
    } t_twr_cfg;

endpackage

@@ rtl/core/twr_in_stage.sv @@
// Input register stage: holds one accepted beat until the engine takes it.
module twr_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  twr_pkg::t_twr_in i_data,
    input  logic             i_take,
    output logic             o_valid,
    output twr_pkg::t_twr_in o_data
);
    import twr_pkg::*;

    logic    r_valid;
    t_twr_in r_data;

    // room when empty or when the held beat leaves this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/core/twr_engine.sv @@
// Session state and the one-pass step logic for packets and timer ticks.
module twr_engine #(
    parameter int BLOCK_BYTES  = twr_pkg::BLOCK_BYTES_DEF,
    parameter int BUFFER_BYTES = twr_pkg::BUFFER_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  twr_pkg::t_twr_in  i_item,
    input  twr_pkg::t_twr_cfg i_cfg,
    output logic              o_has_result,
    output twr_pkg::t_twr_out o_result
);
    import twr_pkg::*;

    localparam int BLK_W = $clog2(BLOCK_BYTES + 1);
    localparam int OFF_W = BLKN_W + BLK_W;
    localparam int BUF_W = $clog2(BUFFER_BYTES + 1);
    localparam int END_W = (OFF_W + 1 > BUF_W) ? OFF_W + 1 : BUF_W;

    t_mode             r_mode,  n_mode;
    logic [PORT_W-1:0] r_peer,  n_peer;
    logic [BLKN_W-1:0] r_cur,   n_cur;
    logic [BLKN_W-1:0] r_prev,  n_prev;
    logic [IDLE_W-1:0] r_idle,  n_idle;
    logic              r_first, n_first;

    logic [IDLE_W-1:0] limit;
    logic [IDLE_W-1:0] idle_inc;
    logic [PLEN_W-1:0] len;
    logic [BLKN_W-1:0] blk_m1;
    logic [OFF_W-1:0]  off;
    logic [END_W-1:0]  off_end;
    logic              over;
    logic              pkt_ok;
    logic              from_wrq;
    t_mode             eff_mode;
    logic [BLKN_W-1:0] eff_prev;
    logic [PORT_W-1:0] eff_peer;
    t_twr_out          res;
    logic              has;

    function automatic t_twr_out make_reply(t_mode m, logic [BLKN_W-1:0] num,
                                            logic [PORT_W-1:0] port);
        t_twr_out r;
        r             = '0;
        r.send_valid  = 1'b1;
        r.send_opcode = (m == MODE_LISTEN) ? SOP_DATA : SOP_ACK;
        r.send_number = num;
        r.reply_port  = port;
        return r;
    endfunction

    // arithmetic that does not depend on the decode
    assign limit    = r_first ? {i_cfg.timeout_ticks, 1'b0} : {1'b0, i_cfg.timeout_ticks};
    assign idle_inc = (&r_idle) ? r_idle : r_idle + IDLE_W'(1);
    assign len      = i_item.packet_len - PLEN_W'(4);
    assign blk_m1   = i_item.block_number - BLKN_W'(1);
    assign off      = OFF_W'(blk_m1) * OFF_W'(BLOCK_BYTES);
    assign off_end  = END_W'(off) + END_W'(len);
    // block zero gives a negative offset
    assign over     = (i_item.block_number == '0) || (off_end > END_W'(BUFFER_BYTES));
    assign pkt_ok   = (i_item.dest_port == i_cfg.our_port)
                   && ((r_mode == MODE_LISTEN) || (i_item.src_port == r_peer))
                   && (i_item.packet_len >= PLEN_W'(2));
    assign from_wrq = (r_mode == MODE_WRQ);
    assign eff_mode = from_wrq ? MODE_DATA : r_mode;
    assign eff_prev = from_wrq ? '0 : r_prev;
    assign eff_peer = from_wrq ? i_item.src_port : r_peer;

    always_comb begin
        n_mode  = r_mode;
        n_peer  = r_peer;
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_idle  = r_idle;
        n_first = r_first;
        res     = '0;
        has     = 1'b0;
        if (i_fire) begin
            if (i_item.kind == KIND_TICK) begin
                if (r_mode != MODE_DONE) begin
                    n_idle = idle_inc;
                    if (idle_inc >= limit) begin
                        n_idle  = '0;
                        n_first = 1'b0;
                        res     = make_reply(r_mode, r_cur, r_peer);
                        has     = 1'b1;
                    end
                end
            end else if (pkt_ok) begin
                case (i_item.opcode)
                    OP_RRQ: begin
                        n_peer = i_item.src_port;
                        n_cur  = BLKN_W'(1);
                        n_mode = MODE_LISTEN;
                        res    = make_reply(MODE_LISTEN, BLKN_W'(1), i_item.src_port);
                        has    = 1'b1;
                    end
                    OP_WRQ: begin
                        n_peer = i_item.src_port;
                        n_cur  = '0;
                        n_mode = MODE_WRQ;
                        res    = make_reply(MODE_WRQ, '0, i_item.src_port);
                        has    = 1'b1;
                    end
                    OP_ERROR: begin
                        n_mode      = MODE_LISTEN;
                        n_cur       = '0;
                        n_idle      = '0;
                        n_first     = 1'b1;
                        res.restart = 1'b1;
                        has         = 1'b1;
                    end
                    OP_DATA: begin
                        if ((r_mode != MODE_DONE) && (i_item.packet_len >= PLEN_W'(4))) begin
                            n_cur  = i_item.block_number;
                            n_mode = eff_mode;
                            n_peer = eff_peer;
                            n_prev = eff_prev;
                            if (from_wrq && (i_item.block_number != BLKN_W'(1))) begin
                                // bad first block
                                n_mode      = MODE_LISTEN;
                                n_cur       = '0;
                                n_idle      = '0;
                                n_first     = 1'b1;
                                res.restart = 1'b1;
                                has         = 1'b1;
                            end else if (i_item.block_number != eff_prev) begin
                                n_prev  = i_item.block_number;
                                n_idle  = '0;
                                n_first = 1'b0;
                                res     = make_reply(eff_mode, i_item.block_number, eff_peer);
                                has     = 1'b1;
                                if (over) begin
                                    res.overflow = 1'b1;
                                end else begin
                                    res.write_valid  = 1'b1;
                                    res.write_offset = WOFF_W'(off);
                                    res.write_length = len;
                                end
                                if (len < PLEN_W'(BLOCK_BYTES)) begin
                                    res.done_res = 1'b1;
                                    n_mode       = MODE_DONE;
                                end
                            end
                        end
                    end
                    default: begin
                        has = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_LISTEN;
            r_peer  <= '0;
            r_cur   <= '0;
            r_prev  <= '0;
            r_idle  <= '0;
            r_first <= 1'b1;
        end else begin
            r_mode  <= n_mode;
            r_peer  <= n_peer;
            r_cur   <= n_cur;
            r_prev  <= n_prev;
            r_idle  <= n_idle;
            r_first <= n_first;
        end
    end

    assign o_has_result = has;
    assign o_result     = res;

endmodule

@@ rtl/core/twr_out_stage.sv @@
// Result register: one beat held for the consumer, refilled as it drains.
module twr_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  twr_pkg::t_twr_out i_data,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output twr_pkg::t_twr_out o_data
);
    import twr_pkg::*;

    logic     r_valid;
    t_twr_out r_data;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/core/tftp_write_receiver.sv @@
// Top level of the TFTP write receiver: config registers and stage wiring.
//
// Channel  Dir  Handshake                 Beat
// in       in   i_in_valid / o_in_ready   packet header or timer tick (t_twr_in)
// out      out  o_out_valid / i_out_ready reply / write / flags (t_twr_out)
// cfg      in   i_cfg_we                  i_cfg_idx selects, i_cfg_data value
//
// One beat per cycle sustained while the output is not stalled. An accepted
// beat lands in the input register; once the result register has room, the
// step logic updates the session state and loads the result register.
// Synchronous active-low reset empties both stages and returns the session to
// listening with port 69 and a 1000 tick timeout.
// A stalled output holds the input register; upstream stalls only once both
// the input and result registers are full. Beats that give no result leave
// nothing in the result register.
`include "tftp_write_receiver_macros.svh"

module tftp_write_receiver #(
    parameter int BLOCK_BYTES  = twr_pkg::BLOCK_BYTES_DEF,
    parameter int BUFFER_BYTES = twr_pkg::BUFFER_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  twr_pkg::t_twr_in                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output twr_pkg::t_twr_out                   o_out_data,
    input  logic                                i_cfg_we,
    input  logic [twr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [twr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import twr_pkg::*;

    logic [PORT_W-1:0] r_port;
    logic [TICK_W-1:0] r_timeout;
    t_twr_cfg          cfg;

    logic     st_valid;
    t_twr_in  st_data;
    logic     out_free;
    logic     fire;
    logic     has_result;
    t_twr_out result;

    // config writes are to be made only while idle, so no shadowing is needed; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port    <= OUR_PORT_RST;
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OUR_PORT: r_port    <= PORT_W'(i_cfg_data);
                REG_TIMEOUT:  r_timeout <= TICK_W'(i_cfg_data);
                default:      r_port    <= r_port;
            endcase
        end
    end

    assign cfg.our_port      = r_port;
    assign cfg.timeout_ticks = r_timeout;

    // the held beat is processed once the result register has room
    assign fire = st_valid && out_free;

    twr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .i_take  (fire),
        .o_valid (st_valid),
        .o_data  (st_data)
    );

    twr_engine #(
        .BLOCK_BYTES  (BLOCK_BYTES),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (st_data),
        .i_cfg        (cfg),
        .o_has_result (has_result),
        .o_result     (result)
    );

    twr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && has_result),
        .i_data  (result),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    // a held beat that cannot move stays held
    `TWR_ASSERT_NXT(a_hold_in, i_clk, i_rst_n, st_valid && !out_free, st_valid)
    // results only come from a processed beat
    `TWR_ASSERT_IMP(a_res_fire, i_clk, i_rst_n, has_result, fire)
    // a restart carries no reply and no write
    `TWR_ASSERT_IMP(a_restart, i_clk, i_rst_n, o_out_valid && o_out_data.restart,
        !o_out_data.send_valid && !o_out_data.write_valid && !o_out_data.done_res)
    // every data block outcome is acknowledged
    `TWR_ASSERT_IMP(a_ack, i_clk, i_rst_n,
        o_out_valid && (o_out_data.write_valid || o_out_data.overflow),
        o_out_data.send_valid && !(o_out_data.write_valid && o_out_data.overflow))
    // unused reply fields read zero
    `TWR_ASSERT_IMP(a_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.send_valid,
        o_out_data.send_opcode == '0 && o_out_data.reply_port == '0)

endmodule
